[src/ukal_pkg.sv]
// Shared types and constants of the unique-key array list engine.
`default_nettype none
package ukal_pkg;
   localparam int CAPACITY = 256;
   localparam int KEY_BITS = 16;
   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = ADDR_BITS + 1;
   localparam int DATA_BITS = 32;
   localparam int REC_BITS = KEY_BITS + DATA_BITS;

   typedef enum logic [3:0] {
      ACT_APPEND = 4'd0, ACT_PREPEND = 4'd1, ACT_INSERT = 4'd2, ACT_DEL_FIRST = 4'd3,
      ACT_DEL_LAST = 4'd4, ACT_DEL_AT = 4'd5, ACT_FIND = 4'd6, ACT_READ = 4'd7,
      ACT_REKEY = 4'd8, ACT_SORT = 4'd9
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_DUP = 3'd1, ST_BADPOS = 3'd2, ST_EMPTY = 3'd3,
      ST_NOTFOUND = 3'd4, ST_FULL = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_PUT, S_FETCH, S_SORT_LOAD,
      S_SORT_CMP, S_SORT_PUT, S_DONE
   } fsm_type;
endpackage
`default_nettype wire

[src/ukal_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ukal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[src/unique_key_array_list_engine_unit.sv]
// Top level of the unique-key array list engine.
// Add and find scan the list once and rekey scans it twice; inserts and deletes then shift
// the records at and behind the target position by one place.
// Sort is an insertion sort over the record RAM.
// Throughput: one item at a time; rsp is held in an output register until taken.
// Synchronous active-high reset clears the count and control; records stay undefined.
`default_nettype none
module unique_key_array_list_engine_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [3:0]                   req_action,
   input  wire logic [15:0]                  req_key_id,
   input  wire logic [15:0]                  req_new_key,
   input  wire logic [31:0]                  req_data_word,
   input  wire logic [8:0]                   req_position,
   input  wire logic                         req_descending,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [7:0]                        rsp_found_index,
   output logic [15:0]                       rsp_out_key,
   output logic [31:0]                       rsp_out_data,
   output logic [8:0]                        rsp_entry_total
);
   import ukal_pkg::*;

   fsm_type state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [3:0] act_ff;
   logic [KEY_BITS-1:0] key_ff, nkey_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [CNT_BITS-1:0] pos_ff;
   logic desc_ff;
   // scan / shift / sort indices
   logic [CNT_BITS-1:0] idx_ff, idx_in;      // address issued
   logic [CNT_BITS-1:0] hit_ff, hit_in;      // key_id location (count = miss)
   logic dup_ff, dup_in;
   logic pass_ff, pass_in;                   // rekey second scan
   logic [CNT_BITS-1:0] si_ff, si_in;        // sort outer index
   logic [REC_BITS-1:0] hold_ff, hold_in;    // sort record in hand
   logic [CNT_BITS-1:0] tgt_ff, tgt_in;      // insert/delete position
   logic rdv_ff;                             // read data valid for address rda_ff
   logic [CNT_BITS-1:0] rda_ff;
   // response register
   logic rv_ff, rv_in;
   logic [2:0] rs_ff, rs_in;
   logic [7:0] rf_ff, rf_in;
   logic [KEY_BITS-1:0] rk_ff, rk_in;
   logic [DATA_BITS-1:0] rd_ff, rd_in;

   // memory
   logic we;
   logic [ADDR_BITS-1:0] wa, ra;
   logic [REC_BITS-1:0] wd, rq;
   logic [KEY_BITS-1:0] rq_key;
   logic [CNT_BITS-1:0] rd_addr_full;
   logic rd_issue;

   ukal_ram #(.WIDTH(REC_BITS), .DEPTH(CAPACITY)) u_rec (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rq)
   );
   assign rq_key = rq[REC_BITS-1:DATA_BITS];
   assign ra = rd_addr_full[ADDR_BITS-1:0];

   logic sort_move;
   assign sort_move = desc_ff ? (rq_key < hold_ff[REC_BITS-1:DATA_BITS])
                              : (rq_key > hold_ff[REC_BITS-1:DATA_BITS]);

   // Next state and datapath
   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; hit_in = hit_ff;
      dup_in = dup_ff; pass_in = pass_ff; si_in = si_ff; hold_in = hold_ff;
      tgt_in = tgt_ff; rv_in = rv_ff; rs_in = rs_ff; rf_in = rf_ff; rk_in = rk_ff;
      rd_in = rd_ff; we = 1'b0; wa = '0; wd = '0; rd_addr_full = idx_ff; rd_issue = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               idx_in = '0; hit_in = count_ff; dup_in = 1'b0; pass_in = 1'b0;
               rs_in = ST_OK; rf_in = '0; rk_in = '0; rd_in = '0;
               case (req_action)
                  ACT_APPEND, ACT_PREPEND, ACT_INSERT, ACT_FIND, ACT_REKEY:
                     state_in = S_SCAN;
                  ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AT, ACT_READ: state_in = S_DECIDE;
                  ACT_SORT: begin
                     si_in = CNT_BITS'(1); state_in = S_SORT_LOAD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // issue reads 0..count-1, compare previous read data
            rd_addr_full = idx_ff;
            if (rdv_ff) begin
               if (!pass_ff && act_ff != ACT_REKEY && rq_key == key_ff) dup_in = 1'b1;
               if (!pass_ff && rq_key == key_ff && hit_ff == count_ff) hit_in = rda_ff;
               if (pass_ff && rq_key == nkey_ff) dup_in = 1'b1;
            end
            if (idx_ff < count_ff) begin
               rd_issue = 1'b1; idx_in = idx_ff + 1'b1;
            end else if (!rdv_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            tgt_in = '0;
            case (act_ff)
               ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
                  if (dup_ff) begin rs_in = ST_DUP; state_in = S_DONE; end
                  else if (count_ff >= CNT_BITS'(CAPACITY)) begin
                     rs_in = ST_FULL; state_in = S_DONE;
                  end else if (act_ff == ACT_INSERT && pos_ff > count_ff) begin
                     rs_in = ST_BADPOS; state_in = S_DONE;
                  end else begin
                     tgt_in = (act_ff == ACT_APPEND) ? count_ff :
                              (act_ff == ACT_PREPEND) ? '0 : pos_ff;
                     idx_in = count_ff; state_in = S_SHIFT;
                  end
               end
               ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AT: begin
                  if (count_ff == '0) begin rs_in = ST_EMPTY; state_in = S_DONE; end
                  else if (act_ff == ACT_DEL_AT && pos_ff >= count_ff) begin
                     rs_in = ST_BADPOS; state_in = S_DONE;
                  end else begin
                     tgt_in = (act_ff == ACT_DEL_FIRST) ? '0 :
                              (act_ff == ACT_DEL_LAST) ? count_ff - 1'b1 : pos_ff;
                     idx_in = (act_ff == ACT_DEL_FIRST) ? '0 :
                              (act_ff == ACT_DEL_LAST) ? count_ff - 1'b1 : pos_ff;
                     state_in = S_SHIFT;
                  end
               end
               ACT_FIND: begin
                  if (hit_ff == count_ff) begin rs_in = ST_NOTFOUND; state_in = S_DONE; end
                  else begin idx_in = hit_ff; state_in = S_FETCH; end
               end
               ACT_READ: begin
                  if (pos_ff >= count_ff) begin rs_in = ST_BADPOS; state_in = S_DONE; end
                  else begin idx_in = pos_ff; state_in = S_FETCH; end
               end
               ACT_REKEY: begin
                  if (hit_ff == count_ff) begin rs_in = ST_NOTFOUND; state_in = S_DONE; end
                  else if (!pass_ff) begin
                     pass_in = 1'b1; idx_in = '0; state_in = S_SCAN;
                  end else if (dup_ff) begin rs_in = ST_DUP; state_in = S_DONE; end
                  else begin idx_in = hit_ff; state_in = S_FETCH; end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SHIFT: begin
            // insert: move idx-1 to idx while idx > tgt; delete: move idx+1 to idx
            if (act_ff == ACT_APPEND || act_ff == ACT_PREPEND || act_ff == ACT_INSERT) begin
               if (rdv_ff) begin
                  we = 1'b1; wa = ADDR_BITS'(rda_ff + 1'b1); wd = rq;
               end
               if (idx_ff > tgt_ff) begin
                  rd_addr_full = idx_ff - 1'b1; rd_issue = 1'b1; idx_in = idx_ff - 1'b1;
               end else if (!rdv_ff) begin
                  state_in = S_PUT;
               end
            end else begin
               if (rdv_ff) begin
                  we = 1'b1; wa = ADDR_BITS'(rda_ff - 1'b1); wd = rq;
               end
               if (idx_ff + 1'b1 < count_ff) begin
                  rd_addr_full = idx_ff + 1'b1; rd_issue = 1'b1; idx_in = idx_ff + 1'b1;
               end else if (!rdv_ff) begin
                  count_in = count_ff - 1'b1; state_in = S_DONE;
               end
            end
         end
         S_PUT: begin
            we = 1'b1; wa = ADDR_BITS'(tgt_ff); wd = {key_ff, data_ff};
            count_in = count_ff + 1'b1; state_in = S_DONE;
         end
         S_FETCH: begin
            rd_addr_full = idx_ff;
            if (!rdv_ff) rd_issue = 1'b1;
            else begin
               if (act_ff == ACT_REKEY) begin
                  we = 1'b1; wa = ADDR_BITS'(idx_ff); wd = {nkey_ff, rq[DATA_BITS-1:0]};
               end else begin
                  rf_in = idx_ff[7:0]; rk_in = rq_key; rd_in = rq[DATA_BITS-1:0];
               end
               state_in = S_DONE;
            end
         end
         S_SORT_LOAD: begin
            // fetch record si into hand
            rd_addr_full = si_ff;
            if (si_ff >= count_ff) state_in = S_DONE;
            else if (!rdv_ff) rd_issue = 1'b1;
            else begin
               hold_in = rq; idx_in = si_ff; state_in = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            // read idx-1 and compare with hand
            rd_addr_full = idx_ff - 1'b1;
            if (idx_ff == '0) state_in = S_SORT_PUT;
            else if (!rdv_ff) rd_issue = 1'b1;
            else if (sort_move) begin
               we = 1'b1; wa = ADDR_BITS'(idx_ff); wd = rq; idx_in = idx_ff - 1'b1;
            end else state_in = S_SORT_PUT;
         end
         S_SORT_PUT: begin
            we = 1'b1; wa = ADDR_BITS'(idx_ff); wd = hold_ff;
            si_in = si_ff + 1'b1; state_in = S_SORT_LOAD;
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rv_ff <= 1'b0; rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in; rdv_ff <= rd_issue;
      end
      rda_ff <= rd_addr_full;
      idx_ff <= idx_in; hit_ff <= hit_in; dup_ff <= dup_in; pass_ff <= pass_in;
      si_ff <= si_in; hold_ff <= hold_in; tgt_ff <= tgt_in;
      rs_ff <= rs_in; rf_ff <= rf_in; rk_ff <= rk_in; rd_ff <= rd_in;
      if (state_ff == S_IDLE && req_valid && !rv_ff) begin
         act_ff <= req_action; key_ff <= KEY_BITS'(req_key_id);
         nkey_ff <= KEY_BITS'(req_new_key); data_ff <= req_data_word;
         pos_ff <= CNT_BITS'(req_position); desc_ff <= req_descending;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_found_index = rf_ff;
   assign rsp_out_key = 16'(rk_ff);
   assign rsp_out_data = rd_ff;
   assign rsp_entry_total = 9'(count_ff);
endmodule
`default_nettype wire

[src/ukal_checker.sv]
// Port-level checker for the array list engine, bound to the top level.
`default_nettype none
module ukal_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [8:0]  rsp_entry_total,
   input wire logic [31:0] rsp_out_data
);
   import ukal_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_total))
      else $error("rsp changed while stalled");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_total <= 9'(CAPACITY))
      else $error("entry total out of range");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'(ST_FULL))
      else $error("bad status code");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 3'(ST_OK) |-> rsp_out_data == '0)
      else $error("payload on failure");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result waits");
endmodule

bind unique_key_array_list_engine_unit ukal_checker u_ukal_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_entry_total(rsp_entry_total), .rsp_out_data(rsp_out_data)
);
`default_nettype wire

[test/ukal_list_checker.sv]
// Transfer monitor, list predictor and result comparison for the list engine.
`timescale 1ns / 1ps
module ukal_list_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [3:0]  req_action,
   input  wire logic [15:0] req_key_id,
   input  wire logic [15:0] req_new_key,
   input  wire logic [31:0] req_data_word,
   input  wire logic [8:0]  req_position,
   input  wire logic        req_descending,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [7:0]  rsp_found_index,
   input  wire logic [15:0] rsp_out_key,
   input  wire logic [31:0] rsp_out_data,
   input  wire logic [8:0]  rsp_entry_total,
   output int               fail_count,
   output int               pending,
   output int               list_size,
   output int               max_size,
   output int               rsp_total
);
   import ukal_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  index;
      logic [15:0] key;
      logic [31:0] data;
      logic [8:0]  total;
   } list_result_type;

   logic [15:0]     model_keys [CAPACITY];
   logic [31:0]     model_data [CAPACITY];
   int              model_count;
   list_result_type result_q [$];

   // Position of a key, or the record count when absent.
   function automatic int locate_key(logic [15:0] k);
      for (int i = 0; i < model_count; i++)
         if (model_keys[i] == k) return i;
      return model_count;
   endfunction

   task automatic put_record(int pos, logic [15:0] k, logic [31:0] d);
      for (int i = model_count; i > pos; i--) begin
         model_keys[i] = model_keys[i-1];
         model_data[i] = model_data[i-1];
      end
      model_keys[pos] = k;
      model_data[pos] = d;
      model_count++;
   endtask

   task automatic drop_record(int pos);
      for (int i = pos; i + 1 < model_count; i++) begin
         model_keys[i] = model_keys[i+1];
         model_data[i] = model_data[i+1];
      end
      model_count--;
   endtask

   task automatic sort_records(logic desc);
      logic [15:0] k;
      logic [31:0] d;
      int j;
      for (int i = 1; i < model_count; i++) begin
         k = model_keys[i];
         d = model_data[i];
         j = i;
         while (j > 0 && (desc ? model_keys[j-1] < k : model_keys[j-1] > k)) begin
            model_keys[j] = model_keys[j-1];
            model_data[j] = model_data[j-1];
            j--;
         end
         model_keys[j] = k;
         model_data[j] = d;
      end
   endtask

   // Work out the result of one request and update the list copy.
   task automatic predict_list_op(output list_result_type r);
      int idx;
      int pos;
      r = '0;
      r.status = ST_OK;
      pos = int'(req_position);
      case (req_action)
         ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
            if (locate_key(req_key_id) != model_count) r.status = ST_DUP;
            else if (model_count >= CAPACITY) r.status = ST_FULL;
            else if (req_action == ACT_INSERT && pos > model_count) r.status = ST_BADPOS;
            else put_record(req_action == ACT_APPEND ? model_count :
                            (req_action == ACT_PREPEND ? 0 : pos),
                            req_key_id, req_data_word);
         end
         ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AT: begin
            if (model_count == 0) r.status = ST_EMPTY;
            else if (req_action == ACT_DEL_AT && pos >= model_count) r.status = ST_BADPOS;
            else drop_record(req_action == ACT_DEL_FIRST ? 0 :
                             (req_action == ACT_DEL_LAST ? model_count - 1 : pos));
         end
         ACT_FIND: begin
            idx = locate_key(req_key_id);
            if (idx == model_count) r.status = ST_NOTFOUND;
            else begin
               r.index = idx[7:0];
               r.key   = model_keys[idx];
               r.data  = model_data[idx];
            end
         end
         ACT_READ: begin
            if (pos >= model_count) r.status = ST_BADPOS;
            else begin
               r.index = pos[7:0];
               r.key   = model_keys[pos];
               r.data  = model_data[pos];
            end
         end
         ACT_REKEY: begin
            idx = locate_key(req_key_id);
            if (idx == model_count) r.status = ST_NOTFOUND;
            else if (locate_key(req_new_key) != model_count) r.status = ST_DUP;
            else model_keys[idx] = req_new_key;
         end
         ACT_SORT: sort_records(req_descending);
         default: ;
      endcase
      r.total = model_count[8:0];
   endtask

   // Compare each result transfer first, then predict each request transfer.
   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (reset) begin
         model_count = 0;
         result_q.delete();
         fail_count <= 0;
         rsp_total  <= 0;
         max_size   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_found_index, rsp_out_key, rsp_out_data, rsp_entry_total};
            rsp_total <= rsp_total + 1;
            if (result_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result transfer with nothing outstanding: %h", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = result_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("%0t: mismatch (expected/actual) status %0d/%0d index %0d/%0d",
                              $realtime, want.status, got.status, want.index, got.index);
                     $display("   key %h/%h data %h/%h total %0d/%0d",
                              want.key, got.key, want.data, got.data, want.total, got.total);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_list_op(want);
            result_q.push_back(want);
            if (model_count > max_size) max_size <= model_count;
         end
      end
      pending   <= result_q.size();
      list_size <= model_count;
   end
endmodule

[test/tb_unique_key_array_list_engine_unit.sv]
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_unique_key_array_list_engine_unit;
   import ukal_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_action = '0;
   logic [15:0] req_key_id = '0;
   logic [15:0] req_new_key = '0;
   logic [31:0] req_data_word = '0;
   logic [8:0]  req_position = '0;
   logic        req_descending = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_found_index;
   logic [15:0] rsp_out_key;
   logic [31:0] rsp_out_data;
   logic [8:0]  rsp_entry_total;
   int          fail_count, pending, list_size, max_size, rsp_total;
   bit          quiet = 1'b0;
   int          sent = 0;

   always #6 clock = ~clock;

   unique_key_array_list_engine_unit dut (.*);
   ukal_list_checker checker_i (.*);

   // Hold off the result side in random bursts until the quiet tail.
   always @(negedge clock) begin
      int stall;
      if (stall > 0) begin
         rsp_ready <= 1'b0;
         stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall = int'($urandom_range(0, 8));
      end else
         rsp_ready <= 1'b1;
   end

   // Present one request and hold it until the transfer.
   task automatic send_op(logic [3:0] act, logic [15:0] k, logic [15:0] nk,
                          logic [31:0] d, logic [8:0] pos, logic desc);
      int gap;
      @(negedge clock);
      gap = (!quiet && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 9)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_key_id     <= k;
      req_new_key    <= nk;
      req_data_word  <= d;
      req_position   <= pos;
      req_descending <= desc;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Keys mostly from a small pool so duplicates and hits are common.
   function automatic logic [15:0] pick_key();
      case ($urandom_range(0, 9))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2, 3: return 16'($urandom_range(0, 16'hFFFF));
         default: return 16'($urandom_range(0, 40));
      endcase
   endfunction

   function automatic logic [8:0] pick_pos();
      case ($urandom_range(0, 9))
         0: return 9'($urandom_range(0, 511));
         1: return 9'h1FF;
         default: return 9'($urandom_range(0, list_size + 1));
      endcase
   endfunction

   task automatic random_op();
      logic [3:0] act;
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) act = 4'($urandom_range(10, 15));
      else if (r < 6) act = ACT_SORT;
      else if (list_size > 30) act = 4'($urandom_range(ACT_DEL_FIRST, ACT_DEL_AT));
      else act = 4'($urandom_range(ACT_APPEND, ACT_REKEY));
      send_op(act, pick_key(), pick_key(), $urandom(), pick_pos(),
              1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-list cases, extremes, each action and each failure path but a full list.
      send_op(ACT_FIND, 16'h0000, 16'h0000, 32'h0, 9'd0, 1'b0);
      send_op(ACT_READ, 16'h0000, 16'h0000, 32'h0, 9'd0, 1'b0);
      send_op(ACT_DEL_FIRST, 16'h0, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_DEL_LAST, 16'h0, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_DEL_AT, 16'h0, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_SORT, 16'h0, 16'h0, 32'h0, 9'd0, 1'b1);
      send_op(ACT_APPEND, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 9'h1FF, 1'b1);
      send_op(ACT_SORT, 16'h0, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_PREPEND, 16'hFFFF, 16'h0, 32'h0000_0000, 9'd0, 1'b0);
      send_op(ACT_INSERT, 16'h1234, 16'h0, 32'hA5A5_5A5A, 9'd2, 1'b0);
      send_op(ACT_INSERT, 16'h4321, 16'h0, 32'h1, 9'd4, 1'b0);
      send_op(ACT_INSERT, 16'h4321, 16'h0, 32'h1, 9'h1FF, 1'b0);
      send_op(ACT_APPEND, 16'h1234, 16'h0, 32'h2, 9'd0, 1'b0);
      send_op(ACT_REKEY, 16'h7777, 16'h0001, 32'h0, 9'd0, 1'b0);
      send_op(ACT_REKEY, 16'h1234, 16'h1234, 32'h0, 9'd0, 1'b0);
      send_op(ACT_REKEY, 16'h1234, 16'hFFFF, 32'h0, 9'd0, 1'b0);
      send_op(ACT_REKEY, 16'h1234, 16'h8000, 32'h0, 9'd0, 1'b0);
      send_op(ACT_FIND, 16'h8000, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_FIND, 16'h5555, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_READ, 16'h0, 16'h0, 32'h0, 9'd1, 1'b0);
      send_op(ACT_READ, 16'h0, 16'h0, 32'h0, 9'd3, 1'b0);
      send_op(ACT_DEL_AT, 16'h0, 16'h0, 32'h0, 9'd3, 1'b0);
      send_op(ACT_SORT, 16'h0, 16'h0, 32'h0, 9'd0, 1'b1);
      send_op(4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 9'h1FF, 1'b1);
      send_op(ACT_DEL_AT, 16'h0, 16'h0, 32'h0, 9'd1, 1'b0);

      // Fill to capacity, probe the full list, sort it both ways, then drain.
      while (list_size < CAPACITY || pending != 0)
         if (pending == 0)
            send_op(ACT_APPEND, 16'($urandom()), 16'h0, $urandom(), 9'd0, 1'b0);
         else
            @(negedge clock);
      send_op(ACT_APPEND, 16'hFFFE, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_INSERT, 16'hFFFE, 16'h0, 32'h0, 9'd256, 1'b0);
      send_op(ACT_SORT, 16'h0, 16'h0, 32'h0, 9'd0, 1'b1);
      send_op(ACT_READ, 16'h0, 16'h0, 32'h0, 9'd255, 1'b0);
      send_op(ACT_SORT, 16'h0, 16'h0, 32'h0, 9'd0, 1'b0);
      send_op(ACT_READ, 16'h0, 16'h0, 32'h0, 9'd255, 1'b0);
      send_op(ACT_DEL_AT, 16'h0, 16'h0, 32'h0, 9'd256, 1'b0);
      send_op(ACT_DEL_AT, 16'h0, 16'h0, 32'h0, 9'd128, 1'b0);
      repeat (CAPACITY - 1) send_op(4'($urandom_range(ACT_DEL_FIRST, ACT_DEL_LAST)),
                                    16'h0, 16'h0, 32'h0, 9'd0, 1'b0);

      // Random traffic, with one full drain part-way through.
      for (int n = 0; n < 1500; n++) begin
         if (n == 750) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if (n == 1350) quiet = 1'b1;
         random_op();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the remaining results, then allow for the block's latency.
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("Sent %0d requests and checked %0d results over all ten actions.",
               sent, rsp_total);
      $display("Largest list held: %0d records, including a full list sorted both ways.",
               max_size);
      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #200_000_000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
